// ===== rtl/core/csc_pkg.sv =====
package csc_pkg;

  localparam int MOMENTUM_BITS_DEF        = 20;
  localparam int COSINE_FRACTION_BITS_DEF = 14;

  typedef struct packed {
    logic vld;
    logic ok;
    logic neg;
  } csc_ctl_t;

endpackage

// ===== rtl/core/csc_front.sv =====
module csc_front
  import csc_pkg::*;
#(
  parameter int MB = MOMENTUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [MB-2:0]       first_energy,
  input  logic [MB-1:0]       first_px,
  input  logic [MB-1:0]       first_py,
  input  logic [MB-1:0]       first_pz,
  input  logic                first_positive,
  input  logic [MB-2:0]       second_energy,
  input  logic [MB-1:0]       second_px,
  input  logic [MB-1:0]       second_py,
  input  logic [MB-1:0]       second_pz,
  input  logic                second_positive,
  output csc_ctl_t            ctl,
  output logic [2*MB-1:0]     m2,
  output logic [2*MB-1:0]     bb,
  output logic [2*MB-1:0]     nmag
);

  // stage 1: order leptons, form sums
  logic              s1_vld_r, s1_ok_r;
  logic [MB-1:0]     s1_esum_r;
  logic [MB:0]       s1_pxs_r, s1_pys_r, s1_pzs_r;
  logic [MB-2:0]     s1_ea_r, s1_eb_r;
  logic [MB-1:0]     s1_pza_r, s1_pzb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_ok_r   <= first_positive ^ second_positive;
    s1_esum_r <= {1'b0, first_energy} + {1'b0, second_energy};
    s1_pxs_r  <= {first_px[MB-1], first_px} + {second_px[MB-1], second_px};
    s1_pys_r  <= {first_py[MB-1], first_py} + {second_py[MB-1], second_py};
    s1_pzs_r  <= {first_pz[MB-1], first_pz} + {second_pz[MB-1], second_pz};
    if (first_positive) begin
      s1_ea_r  <= second_energy;
      s1_pza_r <= second_pz;
      s1_eb_r  <= first_energy;
      s1_pzb_r <= first_pz;
    end else begin
      s1_ea_r  <= first_energy;
      s1_pza_r <= first_pz;
      s1_eb_r  <= second_energy;
      s1_pzb_r <= second_pz;
    end
  end

  // stage 2: squares and cross products
  logic [MB:0]        pxm, pym, pzm;
  logic [2*MB+1:0]    pxsq_full, pysq_full, bsq_full;
  logic               s2_vld_r, s2_ok_r, s2_pzneg_r;
  logic [2*MB-1:0]    s2_esq_r;
  logic [2*MB:0]      s2_pxsq_r, s2_pysq_r, s2_bsq_r;
  logic signed [2*MB-1:0] s2_p1_r, s2_p2_r;

  assign pxm = s1_pxs_r[MB] ? (~s1_pxs_r + 1'b1) : s1_pxs_r;
  assign pym = s1_pys_r[MB] ? (~s1_pys_r + 1'b1) : s1_pys_r;
  assign pzm = s1_pzs_r[MB] ? (~s1_pzs_r + 1'b1) : s1_pzs_r;
  assign pxsq_full = pxm * pxm;
  assign pysq_full = pym * pym;
  assign bsq_full  = pzm * pzm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_ok_r    <= s1_ok_r && (s1_pzs_r != '0);
    s2_pzneg_r <= s1_pzs_r[MB];
    s2_esq_r   <= s1_esum_r * s1_esum_r;
    s2_pxsq_r  <= pxsq_full[2*MB:0];
    s2_pysq_r  <= pysq_full[2*MB:0];
    s2_bsq_r   <= bsq_full[2*MB:0];
    s2_p1_r    <= $signed(s1_pza_r) * $signed({1'b0, s1_eb_r});
    s2_p2_r    <= $signed({1'b0, s1_ea_r}) * $signed(s1_pzb_r);
  end

  // stage 3: mass squared, B, numerator
  logic [2*MB+2:0]     psq, esq_x, m2_full;
  logic [2*MB:0]       bb_full;
  logic signed [2*MB:0] dd;
  logic [2*MB:0]       dmag;
  csc_ctl_t            s3_ctl_r;
  logic [2*MB-1:0]     s3_m2_r, s3_bb_r, s3_n_r;

  assign psq     = {2'b00, s2_pxsq_r} + {2'b00, s2_pysq_r} + {2'b00, s2_bsq_r};
  assign esq_x   = {3'b000, s2_esq_r};
  assign m2_full = esq_x - psq;
  assign bb_full = {1'b0, s2_esq_r} - s2_bsq_r;
  assign dd      = {s2_p1_r[2*MB-1], s2_p1_r} - {s2_p2_r[2*MB-1], s2_p2_r};
  assign dmag    = dd[2*MB] ? (~dd + 1'b1) : dd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r.vld <= 1'b0;
    end else begin
      s3_ctl_r.vld <= s2_vld_r;
    end
    s3_ctl_r.ok  <= s2_ok_r && (esq_x > psq);
    s3_ctl_r.neg <= dd[2*MB] ^ s2_pzneg_r;
    s3_m2_r      <= m2_full[2*MB-1:0];
    s3_bb_r      <= bb_full[2*MB-1:0];
    s3_n_r       <= {dmag[2*MB-2:0], 1'b0};
  end

  assign ctl  = s3_ctl_r;
  assign m2   = s3_m2_r;
  assign bb   = s3_bb_r;
  assign nmag = s3_n_r;

endmodule

// ===== rtl/core/csc_mult.sv =====
module csc_mult
  import csc_pkg::*;
#(
  parameter int MB = MOMENTUM_BITS_DEF,
  parameter int F  = COSINE_FRACTION_BITS_DEF,
  parameter int AW = 4*MB,
  parameter int RW = 4*MB + 2*F + 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  csc_ctl_t        ctl_in,
  input  logic [2*MB-1:0] m2,
  input  logic [2*MB-1:0] bb,
  input  logic [2*MB-1:0] nmag,
  output csc_ctl_t        ctl_out,
  output logic [AW-1:0]   ab,
  output logic [RW-1:0]   rhs
);

  // stage 4: half-width partial products
  csc_ctl_t         s4_ctl_r;
  logic [2*MB-1:0]  s4_ll_r, s4_lh_r, s4_hl_r, s4_hh_r;
  logic [2*MB-1:0]  s4_nll_r, s4_nlh_r, s4_nhh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r.vld <= 1'b0;
    end else begin
      s4_ctl_r.vld <= ctl_in.vld;
    end
    s4_ctl_r.ok  <= ctl_in.ok;
    s4_ctl_r.neg <= ctl_in.neg;
    s4_ll_r  <= m2[MB-1:0]      * bb[MB-1:0];
    s4_lh_r  <= m2[MB-1:0]      * bb[2*MB-1:MB];
    s4_hl_r  <= m2[2*MB-1:MB]   * bb[MB-1:0];
    s4_hh_r  <= m2[2*MB-1:MB]   * bb[2*MB-1:MB];
    s4_nll_r <= nmag[MB-1:0]    * nmag[MB-1:0];
    s4_nlh_r <= nmag[MB-1:0]    * nmag[2*MB-1:MB];
    s4_nhh_r <= nmag[2*MB-1:MB] * nmag[2*MB-1:MB];
  end

  // stage 5: sum partial products
  logic [AW-1:0] ab_sum, nsq_sum;
  csc_ctl_t      s5_ctl_r;
  logic [AW-1:0] s5_ab_r;
  logic [RW-1:0] s5_rhs_r;

  assign ab_sum  = ({{(2*MB){1'b0}}, s4_hh_r} << (2*MB))
                 + ({{(2*MB){1'b0}}, s4_lh_r} << MB)
                 + ({{(2*MB){1'b0}}, s4_hl_r} << MB)
                 + {{(2*MB){1'b0}}, s4_ll_r};
  assign nsq_sum = ({{(2*MB){1'b0}}, s4_nhh_r} << (2*MB))
                 + ({{(2*MB){1'b0}}, s4_nlh_r} << (MB + 1))
                 + {{(2*MB){1'b0}}, s4_nll_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_ctl_r.vld <= 1'b0;
    end else begin
      s5_ctl_r.vld <= s4_ctl_r.vld;
    end
    s5_ctl_r.ok  <= s4_ctl_r.ok;
    s5_ctl_r.neg <= s4_ctl_r.neg;
    s5_ab_r      <= ab_sum;
    s5_rhs_r     <= {{(RW-AW){1'b0}}, nsq_sum} << (2*F);
  end

  assign ctl_out = s5_ctl_r;
  assign ab      = s5_ab_r;
  assign rhs     = s5_rhs_r;

endmodule

// ===== rtl/core/csc_digit.sv =====
module csc_digit
  import csc_pkg::*;
#(
  parameter int F  = COSINE_FRACTION_BITS_DEF,
  parameter int K  = 0,
  parameter int AW = 80,
  parameter int RW = 111
) (
  input  logic          clk,
  input  logic          rst_n,
  input  csc_ctl_t      ctl_in,
  input  logic          sat_in,
  input  logic [F:0]    q_in,
  input  logic [RW-1:0] rem_in,
  input  logic [RW-1:0] t_in,
  input  logic [AW-1:0] ab_in,
  output csc_ctl_t      ctl_out,
  output logic          sat_out,
  output logic [F:0]    q_out,
  output logic [RW-1:0] rem_out,
  output logic [RW-1:0] t_out,
  output logic [AW-1:0] ab_out
);

  logic [RW-1:0] ab_x, cand;
  logic          pass;
  csc_ctl_t      ctl_r;
  logic          sat_r;
  logic [F:0]    q_r;
  logic [RW-1:0] rem_r, t_r;
  logic [AW-1:0] ab_r;

  // try setting bit K: (q + 2^K)^2 * ab <= rhs
  assign ab_x = {{(RW-AW){1'b0}}, ab_in};
  assign cand = (t_in << (K + 1)) + (ab_x << (2*K));
  assign pass = !sat_in && (cand <= rem_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= ctl_in.vld;
    end
    ctl_r.ok  <= ctl_in.ok;
    ctl_r.neg <= ctl_in.neg;
    ab_r      <= ab_in;
    if (pass) begin
      sat_r <= sat_in || (K == F);
      q_r   <= q_in | ((F+1)'(1) << K);
      rem_r <= rem_in - cand;
      t_r   <= t_in + (ab_x << K);
    end else begin
      sat_r <= sat_in;
      q_r   <= q_in;
      rem_r <= rem_in;
      t_r   <= t_in;
    end
  end

  assign ctl_out = ctl_r;
  assign sat_out = sat_r;
  assign q_out   = q_r;
  assign rem_out = rem_r;
  assign t_out   = t_r;
  assign ab_out  = ab_r;

endmodule

// ===== rtl/core/collins_soper_cosine_top.sv =====
// Collins-Soper cosine of a lepton pair.
// Input channel: drive the in_ ports with two leptons (energy, px, py, pz,
// charge sign) and raise start; an item is taken at each rising edge with
// start high and busy low. busy stays low, so a new item may enter on
// every cycle.
// Result channel: out_strobe marks one cycle holding out_cos_theta (signed,
// COSINE_FRACTION_BITS fraction bits, truncated toward zero, saturated to
// plus or minus one) and out_result_valid. The receiver cannot stall; each
// result is shown once.
// Pipeline: three front stages (ordering and sums, squares, mass and
// numerator), two multiply stages, one compare/subtract stage per result
// bit, one output register. Throughput is one item per cycle.
// Same-sign pairs, zero pz sum and non-positive mass squared give
// out_result_valid low and a zero cosine.
// Reset (rst_n low, synchronous) drops all items in flight.
module collins_soper_cosine_top
  import csc_pkg::*;
#(
  parameter int MOMENTUM_BITS        = MOMENTUM_BITS_DEF,
  parameter int COSINE_FRACTION_BITS = COSINE_FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [MOMENTUM_BITS-2:0]        in_first_energy,
  input  logic [MOMENTUM_BITS-1:0]        in_first_px,
  input  logic [MOMENTUM_BITS-1:0]        in_first_py,
  input  logic [MOMENTUM_BITS-1:0]        in_first_pz,
  input  logic                            in_first_positive,
  input  logic [MOMENTUM_BITS-2:0]        in_second_energy,
  input  logic [MOMENTUM_BITS-1:0]        in_second_px,
  input  logic [MOMENTUM_BITS-1:0]        in_second_py,
  input  logic [MOMENTUM_BITS-1:0]        in_second_pz,
  input  logic                            in_second_positive,
  output logic                            out_strobe,
  output logic [COSINE_FRACTION_BITS+1:0] out_cos_theta,
  output logic                            out_result_valid
);

  localparam int MB = MOMENTUM_BITS;
  localparam int F  = COSINE_FRACTION_BITS;
  localparam int AW = 4*MB;
  localparam int RW = 4*MB + 2*F + 3;

  csc_ctl_t        fr_ctl, mu_ctl;
  logic [2*MB-1:0] fr_m2, fr_bb, fr_n;
  logic [AW-1:0]   mu_ab;
  logic [RW-1:0]   mu_rhs;

  assign busy = 1'b0;

  csc_front #(.MB(MB)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_vld          (start && !busy),
    .first_energy    (in_first_energy),
    .first_px        (in_first_px),
    .first_py        (in_first_py),
    .first_pz        (in_first_pz),
    .first_positive  (in_first_positive),
    .second_energy   (in_second_energy),
    .second_px       (in_second_px),
    .second_py       (in_second_py),
    .second_pz       (in_second_pz),
    .second_positive (in_second_positive),
    .ctl             (fr_ctl),
    .m2              (fr_m2),
    .bb              (fr_bb),
    .nmag            (fr_n)
  );

  csc_mult #(.MB(MB), .F(F), .AW(AW), .RW(RW)) u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (fr_ctl),
    .m2      (fr_m2),
    .bb      (fr_bb),
    .nmag    (fr_n),
    .ctl_out (mu_ctl),
    .ab      (mu_ab),
    .rhs     (mu_rhs)
  );

  csc_ctl_t      dg_ctl [0:F+1];
  logic          dg_sat [0:F+1];
  logic [F:0]    dg_q   [0:F+1];
  logic [RW-1:0] dg_rem [0:F+1];
  logic [RW-1:0] dg_t   [0:F+1];
  logic [AW-1:0] dg_ab  [0:F+1];

  assign dg_ctl[0] = mu_ctl;
  assign dg_sat[0] = 1'b0;
  assign dg_q[0]   = '0;
  assign dg_rem[0] = mu_rhs;
  assign dg_t[0]   = '0;
  assign dg_ab[0]  = mu_ab;

  for (genvar i = 0; i <= F; i++) begin : g_digit
    csc_digit #(.F(F), .K(F - i), .AW(AW), .RW(RW)) u_digit (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_in  (dg_ctl[i]),
      .sat_in  (dg_sat[i]),
      .q_in    (dg_q[i]),
      .rem_in  (dg_rem[i]),
      .t_in    (dg_t[i]),
      .ab_in   (dg_ab[i]),
      .ctl_out (dg_ctl[i+1]),
      .sat_out (dg_sat[i+1]),
      .q_out   (dg_q[i+1]),
      .rem_out (dg_rem[i+1]),
      .t_out   (dg_t[i+1]),
      .ab_out  (dg_ab[i+1])
    );
  end

  logic [F+1:0] q_x, cos_nxt;
  logic         strobe_r, valid_r;
  logic [F+1:0] cos_r;

  assign q_x     = {1'b0, dg_q[F+1]};
  assign cos_nxt = !dg_ctl[F+1].ok ? '0 : (dg_ctl[F+1].neg ? (~q_x + 1'b1) : q_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dg_ctl[F+1].vld;
    end
  end

  always_ff @(posedge clk) begin
    valid_r <= dg_ctl[F+1].ok;
    cos_r   <= cos_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_cos_theta    = cos_r;
  assign out_result_valid = valid_r;

  localparam logic signed [F+1:0] ONE_Q  = (F+2)'(1) << F;
  localparam logic signed [F+1:0] MONE_Q = -ONE_Q;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_result_valid |-> out_cos_theta == '0)
    else $error("invalid result with nonzero cosine");

  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($signed(out_cos_theta) <= ONE_Q) && ($signed(out_cos_theta) >= MONE_Q))
    else $error("cosine outside plus or minus one");

  a_sat_exact: assert property (@(posedge clk) disable iff (!rst_n)
    dg_ctl[F+1].vld && dg_sat[F+1] |-> dg_q[F+1] == ((F+1)'(1) << F))
    else $error("saturated quotient not one");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("strobe after reset");

endmodule
